// ----- rtl/core/qalu_pkg.sv -----
// quaternion alu package: operand and result beat types, opcodes, job classes,
// sequencer states and the saturation helpers shared by the core modules
// depends on nothing
`default_nettype none

package qalu_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int ACC_BITS  = 2 * WORD_BITS + 4;
    localparam int DIV_BITS  = 2 * WORD_BITS;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef word_t [3:0] quat_t;

    localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
    localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});

    // opcodes
    localparam logic [3:0] OP_ADD   = 4'd0;
    localparam logic [3:0] OP_SUB   = 4'd1;
    localparam logic [3:0] OP_MUL   = 4'd2;
    localparam logic [3:0] OP_DIV   = 4'd3;
    localparam logic [3:0] OP_CONJ  = 4'd4;
    localparam logic [3:0] OP_INV   = 4'd5;
    localparam logic [3:0] OP_NORMZ = 4'd6;
    localparam logic [3:0] OP_NORM  = 4'd7;
    localparam logic [3:0] OP_DOT   = 4'd8;
    localparam logic [3:0] OP_DIST  = 4'd9;
    localparam logic [3:0] OP_CHEB  = 4'd10;

    // sign of each hamilton product term, indexed {result part, p part}
    localparam logic [15:0] HAM_NEG = 16'b0100_0010_1000_1110;

    typedef struct packed {
        logic [3:0] req_type;
        word_t      op1_w;
        word_t      op1_x;
        word_t      op1_y;
        word_t      op1_z;
        word_t      op2_w;
        word_t      op2_x;
        word_t      op2_y;
        word_t      op2_z;
    } qalu_req_t;

    typedef struct packed {
        word_t res_w;
        word_t res_x;
        word_t res_y;
        word_t res_z;
        word_t res_scalar;
        logic  zero_norm;
        logic  saturated;
    } qalu_rsp_t;

    typedef enum logic [2:0] {
        CL_ELEM,
        CL_MUL,
        CL_DOT,
        CL_NORM,
        CL_DIST,
        CL_NORMZ,
        CL_INV,
        CL_DIV
    } cls_t;

    typedef struct packed {
        logic [3:0] req_type;
        cls_t       cls;
        quat_t      a;
        quat_t      b;
    } qalu_job_t;

    typedef enum logic [2:0] {
        MM_HAM,
        MM_DOT,
        MM_SQA,
        MM_SQB,
        MM_SQD
    } mac_mode_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ELEM,
        ST_MAC,
        ST_ZCHK,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } st_t;

    function automatic logic signed [WORD_BITS:0] ext_word(input word_t v);
        return {v[WORD_BITS-1], v};
    endfunction

    function automatic logic signed [ACC_BITS-1:0] wide(input logic signed [WORD_BITS:0] v);
        return {{(ACC_BITS-WORD_BITS-1){v[WORD_BITS]}}, v};
    endfunction

    function automatic logic word_ovf(input logic signed [ACC_BITS-1:0] v);
        return !((&v[ACC_BITS-1:WORD_BITS-1]) || !(|v[ACC_BITS-1:WORD_BITS-1]));
    endfunction

    function automatic word_t sat_word(input logic signed [ACC_BITS-1:0] v);
        if (word_ovf(v)) begin
            return v[ACC_BITS-1] ? WORD_MIN : WORD_MAX;
        end
        return v[WORD_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/qalu_front.sv -----
// quaternion alu front: takes operand beats and sorts them into job classes
// depends on qalu_pkg
`default_nettype none

module qalu_front (
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire qalu_pkg::qalu_req_t s_req,
    input  wire logic                queue_full,
    output logic                     push,
    output qalu_pkg::qalu_job_t      job
);
    import qalu_pkg::*;

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    always_comb begin
        job.req_type = s_req.req_type;
        job.a        = {s_req.op1_z, s_req.op1_y, s_req.op1_x, s_req.op1_w};
        job.b        = {s_req.op2_z, s_req.op2_y, s_req.op2_x, s_req.op2_w};
        unique case (s_req.req_type) inside
            OP_MUL:   job.cls = CL_MUL;
            OP_DIV:   job.cls = CL_DIV;
            OP_INV:   job.cls = CL_INV;
            OP_NORMZ: job.cls = CL_NORMZ;
            OP_NORM:  job.cls = CL_NORM;
            OP_DOT:   job.cls = CL_DOT;
            OP_DIST:  job.cls = CL_DIST;
            // add, sub, conj, chebyshev and unknown codes
            default:  job.cls = CL_ELEM;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/qalu_fifo.sv -----
// quaternion alu job queue between front and back, register based
// depends on qalu_pkg
`default_nettype none

module qalu_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire qalu_pkg::qalu_job_t push_job,
    input  wire logic                pop,
    output logic                     full,
    output logic                     head_valid,
    output qalu_pkg::qalu_job_t      head
);
    import qalu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    qalu_job_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_reg, wr_next;
    logic [PTR_W-1:0]     rd_reg, rd_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head       = mem_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/qalu_div.sv -----
// quaternion alu divider: restoring, one quotient bit per cycle
// depends on qalu_pkg
`default_nettype none

module qalu_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [qalu_pkg::DIV_BITS-1:0] dividend,
    input  wire logic [qalu_pkg::DIV_BITS-1:0] divisor,
    output logic                               done,
    output logic [qalu_pkg::DIV_BITS-1:0]      quot
);
    import qalu_pkg::*;

    localparam int CNT_W = $clog2(DIV_BITS + 1);

    logic [DIV_BITS-1:0] rem_reg, rem_next;
    logic [DIV_BITS-1:0] quot_reg, quot_next;
    logic [DIV_BITS-1:0] den_reg;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                run_reg, run_next;
    logic                done_reg, done_next;
    logic [DIV_BITS:0]   shifted;
    logic [DIV_BITS:0]   diff;
    logic                ge;

    assign shifted = {rem_reg, quot_reg[DIV_BITS-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = (shifted >= {1'b0, den_reg});
    assign done    = done_reg;
    assign quot    = quot_reg;

    always_comb begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quot_next = dividend;
            cnt_next  = CNT_W'(DIV_BITS);
            run_next  = 1'b1;
        end else if (run_reg) begin
            rem_next  = ge ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
            quot_next = {quot_reg[DIV_BITS-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (start) begin
            den_reg <= divisor;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/qalu_isqrt.sv -----
// quaternion alu integer square root: floor root, one result bit per cycle
// depends on qalu_pkg
`default_nettype none

module qalu_isqrt (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [qalu_pkg::DIV_BITS-1:0] x,
    output logic                               done,
    output logic [qalu_pkg::WORD_BITS-1:0]     root
);
    import qalu_pkg::*;

    localparam int CNT_W = $clog2(WORD_BITS + 1);

    logic [DIV_BITS-1:0] x_reg, x_next;
    logic [DIV_BITS-1:0] r_reg, r_next;
    logic [DIV_BITS-1:0] bit_reg, bit_next;
    logic [DIV_BITS-1:0] trial;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                run_reg, run_next;
    logic                done_reg, done_next;

    assign trial = r_reg + bit_reg;
    assign done  = done_reg;
    assign root  = r_reg[WORD_BITS-1:0];

    always_comb begin
        x_next    = x_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            x_next   = x;
            r_next   = '0;
            bit_next = DIV_BITS'(1) << (DIV_BITS - 2);
            cnt_next = CNT_W'(WORD_BITS);
            run_next = 1'b1;
        end else if (run_reg) begin
            if (x_reg >= trial) begin
                x_next = x_reg - trial;
                r_next = (r_reg >> 1) + bit_reg;
            end else begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        x_reg   <= x_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/qalu_back.sv -----
// quaternion alu back end: sequencer with a shared multiplier, divider and
// square root unit, plus the result output register
// depends on qalu_pkg, qalu_div, qalu_isqrt
`default_nettype none

module qalu_back (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                head_valid,
    input  wire qalu_pkg::qalu_job_t head,
    output logic                     pop,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output qalu_pkg::qalu_rsp_t      m_rsp
);
    import qalu_pkg::*;

    st_t                        state_reg, state_next;
    cls_t                       cls_reg, cls_next;
    logic [3:0]                 op_reg, op_next;
    mac_mode_t                  mode_reg, mode_next;
    quat_t                      a_reg, a_next;
    quat_t                      b_reg, b_next;
    quat_t                      res_reg, res_next;
    word_t                      sc_reg, sc_next;
    logic                       zn_reg, zn_next;
    logic                       clip_reg, clip_next;
    logic [4:0]                 cnt_reg, cnt_next;
    logic signed [ACC_BITS-1:0] acc_reg, acc_next;
    logic signed [2*WORD_BITS+1:0] prod_reg;
    logic                       pneg_reg;
    logic [DIV_BITS-1:0]        sum_reg, sum_next;
    logic [DIV_BITS-1:0]        den_reg, den_next;
    logic                       dneg_reg, dneg_next;
    logic                       m_valid_reg, m_valid_next;
    qalu_rsp_t                  m_rsp_reg, m_rsp_next;

    // multiplier and accumulator
    logic [1:0]                    mj, mr;
    logic signed [WORD_BITS:0]     mx, my, md;
    logic signed [2*WORD_BITS+1:0] mul_p;
    logic                          mneg;
    logic [4:0]                    mac_n, cm1;
    logic signed [ACC_BITS-1:0]    prod_w, acc_sum, acc_shift;
    logic [DIV_BITS-1:0]           sum_cap;
    logic                          grp_end;

    // element-wise ops
    logic signed [WORD_BITS:0] e_sum, e_diff, e_neg;
    logic [WORD_BITS:0]        e_mag, e_max;

    // divider and root units
    logic                div_start, div_done;
    logic [DIV_BITS-1:0] div_dividend, div_quot, div_cap;
    logic [WORD_BITS-1:0] div_mag, d_mag;
    logic                div_ovf;
    word_t               div_val, d_src;
    logic                sq_start, sq_done;
    logic [WORD_BITS-1:0] sq_root;
    logic                load_job;

    qalu_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (den_reg),
        .done     (div_done),
        .quot     (div_quot)
    );

    qalu_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .x       (sum_reg),
        .done    (sq_done),
        .root    (sq_root)
    );

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

    // operand select for the shared multiplier
    always_comb begin
        mj   = cnt_reg[1:0];
        mr   = cnt_reg[3:2];
        md   = ext_word(a_reg[mj]) - ext_word(b_reg[mj]);
        mneg = 1'b0;
        case (mode_reg)
            MM_HAM: begin
                mx   = ext_word(a_reg[mj]);
                my   = ext_word(b_reg[mr ^ mj]);
                mneg = HAM_NEG[cnt_reg[3:0]];
            end
            MM_DOT: begin
                mx = ext_word(a_reg[mj]);
                my = ext_word(b_reg[mj]);
            end
            MM_SQA: begin
                mx = ext_word(a_reg[mj]);
                my = ext_word(a_reg[mj]);
            end
            MM_SQB: begin
                mx = ext_word(b_reg[mj]);
                my = ext_word(b_reg[mj]);
            end
            default: begin
                mx = md;
                my = md;
            end
        endcase
    end

    assign mul_p     = mx * my;
    assign mac_n     = (mode_reg == MM_HAM) ? 5'd16 : 5'd4;
    assign cm1       = cnt_reg - 5'd1;
    assign grp_end   = (cnt_reg != 5'd0) && (cm1[1:0] == 2'd3);
    assign prod_w    = {{(ACC_BITS-2*WORD_BITS-2){prod_reg[2*WORD_BITS+1]}}, prod_reg};
    assign acc_sum   = acc_reg + (pneg_reg ? -prod_w : prod_w);
    assign acc_shift = acc_sum >>> FRAC_BITS;
    // sum of squares is never negative; cap at the 64-bit maximum
    assign sum_cap   = (|acc_sum[ACC_BITS-1:DIV_BITS]) ? '1 : acc_sum[DIV_BITS-1:0];

    // quotient clamp: magnitude limit depends on the sign of the result
    assign div_cap = {{(DIV_BITS-WORD_BITS){1'b0}}, dneg_reg, {(WORD_BITS-1){~dneg_reg}}};
    assign div_ovf = (div_quot > div_cap);
    assign div_mag = div_ovf ? div_cap[WORD_BITS-1:0] : div_quot[WORD_BITS-1:0];
    assign div_val = dneg_reg ? -div_mag : div_mag;

    // numerator for the part in cnt_reg
    assign d_src = (cls_reg == CL_DIV) ? b_reg[cnt_reg[1:0]] : a_reg[cnt_reg[1:0]];
    assign d_mag = d_src[WORD_BITS-1] ? -d_src : d_src;
    assign div_dividend = (cls_reg == CL_NORMZ)
                          ? (DIV_BITS'(d_mag) << FRAC_BITS)
                          : (DIV_BITS'(d_mag) << (2 * FRAC_BITS));

    always_comb begin
        state_next   = state_reg;
        cls_next     = cls_reg;
        op_next      = op_reg;
        mode_next    = mode_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        res_next     = res_reg;
        sc_next      = sc_reg;
        zn_next      = zn_reg;
        clip_next    = clip_reg;
        cnt_next     = cnt_reg;
        acc_next     = acc_reg;
        sum_next     = sum_reg;
        den_next     = den_reg;
        dneg_next    = dneg_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_rsp_next   = m_rsp_reg;
        div_start    = 1'b0;
        sq_start     = 1'b0;
        load_job     = 1'b0;
        e_max        = '0;
        e_sum        = '0;
        e_diff       = '0;
        e_neg        = '0;
        e_mag        = '0;

        unique case (state_reg)
            ST_IDLE: begin
                load_job = head_valid;
            end
            ST_ELEM: begin
                for (int i = 0; i < 4; i++) begin
                    e_sum  = ext_word(a_reg[i]) + ext_word(b_reg[i]);
                    e_diff = ext_word(a_reg[i]) - ext_word(b_reg[i]);
                    e_neg  = -ext_word(a_reg[i]);
                    e_mag  = e_diff[WORD_BITS] ? -e_diff : e_diff;
                    if (e_mag > e_max) begin
                        e_max = e_mag;
                    end
                    case (op_reg)
                        OP_ADD: begin
                            res_next[i] = sat_word(wide(e_sum));
                            clip_next   = clip_next | word_ovf(wide(e_sum));
                        end
                        OP_SUB: begin
                            res_next[i] = sat_word(wide(e_diff));
                            clip_next   = clip_next | word_ovf(wide(e_diff));
                        end
                        OP_CONJ: begin
                            if (i == 0) begin
                                res_next[i] = a_reg[i];
                            end else begin
                                res_next[i] = sat_word(wide(e_neg));
                                clip_next   = clip_next | word_ovf(wide(e_neg));
                            end
                        end
                        default: begin
                            res_next[i] = '0;
                        end
                    endcase
                end
                if (op_reg == OP_CHEB) begin
                    sc_next   = sat_word(ACC_BITS'(e_max));
                    clip_next = word_ovf(ACC_BITS'(e_max));
                end
                state_next = ST_OUT;
            end
            ST_MAC: begin
                if (cnt_reg != 5'd0) begin
                    acc_next = acc_sum;
                    if (grp_end) begin
                        acc_next = '0;
                        case (mode_reg)
                            MM_HAM: begin
                                res_next[cm1[3:2]] = sat_word(acc_shift);
                                clip_next = clip_next | word_ovf(acc_shift);
                            end
                            MM_DOT: begin
                                sc_next   = sat_word(acc_shift);
                                clip_next = clip_next | word_ovf(acc_shift);
                            end
                            default: begin
                                sum_next = sum_cap;
                            end
                        endcase
                    end
                end
                if (cnt_reg == mac_n) begin
                    state_next = (mode_reg == MM_HAM || mode_reg == MM_DOT) ? ST_OUT : ST_ZCHK;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_ZCHK: begin
                cnt_next = '0;
                acc_next = '0;
                case (cls_reg) inside
                    CL_NORM, CL_DIST: begin
                        state_next = ST_SQRT_GO;
                    end
                    CL_NORMZ: begin
                        if (sum_reg == '0) begin
                            zn_next    = 1'b1;
                            res_next   = a_reg;
                            state_next = ST_OUT;
                        end else begin
                            state_next = ST_SQRT_GO;
                        end
                    end
                    CL_INV: begin
                        if (sum_reg == '0) begin
                            zn_next    = 1'b1;
                            res_next   = a_reg;
                            state_next = ST_OUT;
                        end else begin
                            den_next   = sum_reg;
                            state_next = ST_DIV_GO;
                        end
                    end
                    CL_DIV: begin
                        if (sum_reg == '0) begin
                            // zero divisor: plain product with op2
                            zn_next    = 1'b1;
                            mode_next  = MM_HAM;
                            state_next = ST_MAC;
                        end else begin
                            den_next   = sum_reg;
                            state_next = ST_DIV_GO;
                        end
                    end
                    default: begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_SQRT_GO: begin
                sq_start   = 1'b1;
                state_next = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (sq_done) begin
                    if (cls_reg == CL_NORMZ) begin
                        den_next   = DIV_BITS'(sq_root);
                        cnt_next   = '0;
                        state_next = ST_DIV_GO;
                    end else begin
                        sc_next    = sat_word(ACC_BITS'(sq_root));
                        clip_next  = clip_reg | word_ovf(ACC_BITS'(sq_root));
                        state_next = ST_OUT;
                    end
                end
            end
            ST_DIV_GO: begin
                div_start = 1'b1;
                // inverse uses the conjugate: vector parts flip sign
                if (cls_reg != CL_NORMZ && cnt_reg[1:0] != 2'd0) begin
                    dneg_next = !d_src[WORD_BITS-1] && (d_src != '0);
                end else begin
                    dneg_next = d_src[WORD_BITS-1];
                end
                state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    clip_next = clip_reg | div_ovf;
                    if (cls_reg == CL_DIV) begin
                        b_next[cnt_reg[1:0]] = div_val;
                    end else begin
                        res_next[cnt_reg[1:0]] = div_val;
                    end
                    if (cnt_reg[1:0] == 2'd3) begin
                        cnt_next = '0;
                        acc_next = '0;
                        if (cls_reg == CL_DIV) begin
                            mode_next  = MM_HAM;
                            state_next = ST_MAC;
                        end else begin
                            state_next = ST_OUT;
                        end
                    end else begin
                        cnt_next   = cnt_reg + 5'd1;
                        state_next = ST_DIV_GO;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next          = 1'b1;
                    m_rsp_next.res_w      = res_reg[0];
                    m_rsp_next.res_x      = res_reg[1];
                    m_rsp_next.res_y      = res_reg[2];
                    m_rsp_next.res_z      = res_reg[3];
                    m_rsp_next.res_scalar = sc_reg;
                    m_rsp_next.zero_norm  = zn_reg;
                    m_rsp_next.saturated  = clip_reg;
                    state_next            = ST_IDLE;
                    load_job              = head_valid;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_job) begin
            cls_next  = head.cls;
            op_next   = head.req_type;
            a_next    = head.a;
            b_next    = head.b;
            res_next  = '0;
            sc_next   = '0;
            zn_next   = 1'b0;
            clip_next = 1'b0;
            cnt_next  = '0;
            acc_next  = '0;
            state_next = ST_MAC;
            case (head.cls)
                CL_ELEM:  state_next = ST_ELEM;
                CL_MUL:   mode_next  = MM_HAM;
                CL_DOT:   mode_next  = MM_DOT;
                CL_DIST:  mode_next  = MM_SQD;
                CL_DIV:   mode_next  = MM_SQB;
                default:  mode_next  = MM_SQA;
            endcase
        end
    end

    assign pop = load_job;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cls_reg   <= cls_next;
        op_reg    <= op_next;
        mode_reg  <= mode_next;
        a_reg     <= a_next;
        b_reg     <= b_next;
        res_reg   <= res_next;
        sc_reg    <= sc_next;
        zn_reg    <= zn_next;
        clip_reg  <= clip_next;
        cnt_reg   <= cnt_next;
        acc_reg   <= acc_next;
        sum_reg   <= sum_next;
        den_reg   <= den_next;
        dneg_reg  <= dneg_next;
        m_rsp_reg <= m_rsp_next;
        if (state_reg == ST_MAC && cnt_reg != mac_n) begin
            prod_reg <= mul_p;
            pneg_reg <= mneg;
        end
    end

    a_pop_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("job taken from an empty queue");

    a_div_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> (den_reg != '0))
        else $error("divider started with a zero divisor");

    a_pop_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (state_reg != ST_IDLE && state_reg != ST_OUT))
        else $error("popped job did not start");

    a_mac_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MAC) |-> (cnt_reg <= mac_n))
        else $error("product counter ran past its group");

endmodule

`default_nettype wire

// ----- rtl/core/quaternion_alu.sv -----
// quaternion alu top level: front decoder, job queue and back-end sequencer
// depends on qalu_pkg, qalu_front, qalu_fifo, qalu_back
`default_nettype none

// Quaternion arithmetic unit in signed Q16.16. Each input beat carries an
// opcode and two quaternions; each produces exactly one result beat, in order.
// The front decodes the opcode into a job class and writes the job into a
// queue of QUEUE_DEPTH entries, so s_ready stays high while the queue has
// room, even while the back end is busy or a result is stalled on m_ready.
// The back end runs one job at a time on a single 33x33 multiplier, a
// one-bit-per-cycle divider and a one-bit-per-cycle square root unit, and
// parks each result in an output register. The work per job: add, sub,
// conj, chebyshev and unknown codes take an element-wise step; dot and mul
// run products on the multiplier; norm and distance square and sum the
// parts, pass a zero check, then run a 32-step root; inverse squares, checks
// for zero, then runs four 64-step divides; normalize adds the root before
// the four divides; div runs the inverse of op2, then the hamilton product.
// A zero-norm inverse or normalize skips the root and divides, and a
// zero-norm div skips the divides and runs the product with op2. The sustained
// rate is set by the back end, mainly the divider and root loops; the queue
// absorbs bursts. Inverse, normalize and div by a zero-norm quaternion raise
// zero_norm; any clipped result field raises saturated.

module quaternion_alu #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // operand beats
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire qalu_pkg::qalu_req_t s_req,
    // result beats
    output logic                     m_valid,
    input  wire logic                m_ready,
    output qalu_pkg::qalu_rsp_t      m_rsp
);
    import qalu_pkg::*;

    logic      queue_full;
    logic      push;
    logic      pop;
    logic      head_valid;
    qalu_job_t push_job;
    qalu_job_t head;

    // opcode decode and accept
    qalu_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req      (s_req),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    // decouples accept from execution
    qalu_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head       (head)
    );

    // execution and result register
    qalu_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_rsp      (m_rsp)
    );

endmodule

`default_nettype wire

// ----- tb/sv/qalu_checker.sv -----
// quaternion alu checker: watches both channels, predicts each result beat
// and compares it field by field; depends on qalu_pkg
`timescale 1ns / 100ps

module qalu_checker (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_ready,
    input  wire qalu_pkg::qalu_req_t s_req,
    input  wire logic                m_valid,
    input  wire logic                m_ready,
    input  wire qalu_pkg::qalu_rsp_t m_rsp,
    output int                       pending,
    output int                       fail_count
);
    import qalu_pkg::*;

    typedef logic signed [127:0] big_t;

    localparam big_t W_MAX = (big_t'(1) <<< (WORD_BITS - 1)) - 1;
    localparam big_t W_MIN = -(big_t'(1) <<< (WORD_BITS - 1));
    localparam big_t SQ_CAP = (big_t'(1) <<< 64) - 1;

    qalu_rsp_t rsp_queue[$];

    function automatic word_t clamp(input big_t v, inout logic clip);
        if (v > W_MAX) begin
            clip = 1'b1;
            return word_t'(W_MAX);
        end
        if (v < W_MIN) begin
            clip = 1'b1;
            return word_t'(W_MIN);
        end
        return word_t'(v);
    endfunction

    function automatic big_t magn(input big_t v);
        return v < 0 ? -v : v;
    endfunction

    function automatic big_t sum_sq(input big_t q [4]);
        big_t s;
        s = 0;
        for (int i = 0; i < 4; i++) s += magn(q[i]) * magn(q[i]);
        return s > SQ_CAP ? SQ_CAP : s;
    endfunction

    function automatic big_t floor_root(input big_t v);
        logic [63:0] x, r, b;
        x = v[63:0];
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return big_t'({64'd0, r});
    endfunction

    // c * 2^sh / den, toward zero, clipped to the word range
    function automatic big_t scaled_quot(input big_t c, input int sh, input big_t den,
                                         inout logic clip);
        big_t lim, qv;
        lim = c < 0 ? -W_MIN : W_MAX;
        qv = (magn(c) <<< sh) / den;
        if (qv > lim) begin
            clip = 1'b1;
            qv = lim;
        end
        return c < 0 ? -qv : qv;
    endfunction

    function automatic void ham_product(input big_t p [4], input big_t q [4],
                                        output big_t r [4], inout logic clip);
        r[0] = clamp((p[0]*q[0] - p[1]*q[1] - p[2]*q[2] - p[3]*q[3]) >>> FRAC_BITS, clip);
        r[1] = clamp((p[0]*q[1] + p[1]*q[0] + p[2]*q[3] - p[3]*q[2]) >>> FRAC_BITS, clip);
        r[2] = clamp((p[0]*q[2] - p[1]*q[3] + p[2]*q[0] + p[3]*q[1]) >>> FRAC_BITS, clip);
        r[3] = clamp((p[0]*q[3] + p[1]*q[2] - p[2]*q[1] + p[3]*q[0]) >>> FRAC_BITS, clip);
    endfunction

    // returns 1 on zero norm, leaving r as q
    function automatic logic quat_inverse(input big_t q [4], output big_t r [4],
                                          inout logic clip);
        big_t s;
        s = sum_sq(q);
        if (s == 0) begin
            r = q;
            return 1'b1;
        end
        for (int i = 0; i < 4; i++)
            r[i] = scaled_quot(i == 0 ? q[i] : -q[i], 2 * FRAC_BITS, s, clip);
        return 1'b0;
    endfunction

    function automatic qalu_rsp_t predict_rsp(input qalu_req_t q);
        big_t a [4], b [4], r [4], t [4];
        big_t sc, m;
        logic zn, clip;
        qalu_rsp_t o;
        a[0] = q.op1_w; a[1] = q.op1_x; a[2] = q.op1_y; a[3] = q.op1_z;
        b[0] = q.op2_w; b[1] = q.op2_x; b[2] = q.op2_y; b[3] = q.op2_z;
        for (int i = 0; i < 4; i++) r[i] = 0;
        sc = 0;
        zn = 1'b0;
        clip = 1'b0;
        case (q.req_type)
            OP_ADD: for (int i = 0; i < 4; i++) r[i] = clamp(a[i] + b[i], clip);
            OP_SUB: for (int i = 0; i < 4; i++) r[i] = clamp(a[i] - b[i], clip);
            OP_MUL: ham_product(a, b, r, clip);
            OP_DIV: begin
                zn = quat_inverse(b, t, clip);
                ham_product(a, t, r, clip);
            end
            OP_CONJ: begin
                r[0] = a[0];
                for (int i = 1; i < 4; i++) r[i] = clamp(-a[i], clip);
            end
            OP_INV: zn = quat_inverse(a, r, clip);
            OP_NORMZ: begin
                m = sum_sq(a);
                if (m == 0) begin
                    zn = 1'b1;
                    r = a;
                end else begin
                    m = floor_root(m);
                    for (int i = 0; i < 4; i++) r[i] = scaled_quot(a[i], FRAC_BITS, m, clip);
                end
            end
            OP_NORM: sc = clamp(floor_root(sum_sq(a)), clip);
            OP_DOT: sc = clamp((a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3]) >>> FRAC_BITS,
                               clip);
            OP_DIST: begin
                for (int i = 0; i < 4; i++) t[i] = a[i] - b[i];
                sc = clamp(floor_root(sum_sq(t)), clip);
            end
            OP_CHEB: begin
                m = 0;
                for (int i = 0; i < 4; i++) if (magn(a[i] - b[i]) > m) m = magn(a[i] - b[i]);
                sc = clamp(m, clip);
            end
            default: ;
        endcase
        o.res_w = word_t'(r[0]);
        o.res_x = word_t'(r[1]);
        o.res_y = word_t'(r[2]);
        o.res_z = word_t'(r[3]);
        o.res_scalar = word_t'(sc);
        o.zero_norm = zn;
        o.saturated = clip;
        return o;
    endfunction

    assign pending = rsp_queue.size();

    always @(posedge aclk) begin
        qalu_rsp_t want;
        if (!aresetn) begin
            fail_count <= 0;
        end else begin
            if (s_valid && s_ready) rsp_queue.push_back(predict_rsp(s_req));
            if (m_valid && m_ready) begin
                if (rsp_queue.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count <= fail_count + 1;
                end else begin
                    want = rsp_queue.pop_front();
                    if (want !== m_rsp) begin
                        fail_count <= fail_count + 1;
                        if (want.res_w !== m_rsp.res_w)
                            $error("res_w exp %h got %h", want.res_w, m_rsp.res_w);
                        if (want.res_x !== m_rsp.res_x)
                            $error("res_x exp %h got %h", want.res_x, m_rsp.res_x);
                        if (want.res_y !== m_rsp.res_y)
                            $error("res_y exp %h got %h", want.res_y, m_rsp.res_y);
                        if (want.res_z !== m_rsp.res_z)
                            $error("res_z exp %h got %h", want.res_z, m_rsp.res_z);
                        if (want.res_scalar !== m_rsp.res_scalar)
                            $error("res_scalar exp %h got %h", want.res_scalar, m_rsp.res_scalar);
                        if (want.zero_norm !== m_rsp.zero_norm)
                            $error("zero_norm exp %b got %b", want.zero_norm, m_rsp.zero_norm);
                        if (want.saturated !== m_rsp.saturated)
                            $error("saturated exp %b got %b", want.saturated, m_rsp.saturated);
                    end
                end
            end
        end
    end

endmodule

// ----- tb/sv/tb_quaternion_alu.sv -----
// quaternion alu testbench top: clock, reset, operand and result-side stimulus,
// watchdog and verdict; depends on qalu_pkg, quaternion_alu and qalu_checker
`timescale 1ns / 100ps

module tb_quaternion_alu;
    import qalu_pkg::*;

    localparam int RAND_BEATS = 900;
    localparam int CALM_BEATS = 100;   // tail of the run with no idling
    localparam int STALL_LIMIT = 5000; // above the slowest job, normalize, plus stalls
    localparam word_t ONE = word_t'(32'sh0001_0000);

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    qalu_req_t s_req = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    qalu_rsp_t m_rsp;
    logic      calm = 1'b0;
    int        pending, fail_count, stall_cycles;
    int        idle_left;

    always #2 aclk = ~aclk;

    quaternion_alu uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req(s_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_rsp(m_rsp)
    );

    qalu_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req(s_req),
        .m_valid(m_valid), .m_ready(m_ready), .m_rsp(m_rsp),
        .pending(pending), .fail_count(fail_count)
    );

    // result side: ready, broken by random idle bursts
    always @(posedge aclk) begin
        if (!aresetn || calm) begin
            m_ready   <= aresetn;
            idle_left <= 0;
        end else if (idle_left != 0) begin
            m_ready   <= 1'b0;
            idle_left <= idle_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            m_ready   <= 1'b0;
            idle_left <= int'($urandom_range(0, 8));
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog: cycles with no beat on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one operand beat; valid is held until the handshake
    task automatic send_beat(input qalu_req_t r);
        s_valid <= 1'b1;
        s_req <= r;
        do @(posedge aclk); while (!s_ready);
    endtask

    // sender gap burst, skipped in the calm tail
    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    function automatic word_t rand_word();
        case ($urandom_range(0, 5))
            0: return word_t'($urandom);
            1: case ($urandom_range(0, 4))
                   0: return WORD_MAX;
                   1: return WORD_MIN;
                   2: return '0;
                   3: return ONE;
                   default: return -ONE;
               endcase
            2: return word_t'($urandom_range(0, 32'h00ff_ffff)) - word_t'(32'sh0080_0000);
            default: return word_t'($urandom_range(0, 32'h0008_0000)) - word_t'(32'sh0004_0000);
        endcase
    endfunction

    function automatic qalu_req_t make_req(input logic [3:0] op, input word_t a0, a1, a2, a3,
                                           input word_t b0, b1, b2, b3);
        qalu_req_t r;
        r.req_type = op;
        r.op1_w = a0; r.op1_x = a1; r.op1_y = a2; r.op1_z = a3;
        r.op2_w = b0; r.op2_x = b1; r.op2_y = b2; r.op2_z = b3;
        return r;
    endfunction

    initial begin
        qalu_req_t r;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: every opcode, extremes, zero norms, unknown codes
        send_beat(make_req(OP_ADD, WORD_MAX, WORD_MIN, ONE, '0, WORD_MAX, WORD_MIN, -ONE, '0));
        send_beat(make_req(OP_SUB, WORD_MIN, WORD_MAX, '0, ONE, WORD_MAX, WORD_MIN, '0, -ONE));
        send_beat(make_req(OP_MUL, ONE, ONE, -ONE, ONE, ONE, -ONE, ONE, ONE));
        send_beat(make_req(OP_MUL, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MIN,
                           WORD_MIN, WORD_MAX, WORD_MIN, WORD_MIN));
        send_beat(make_req(OP_DIV, ONE, ONE, ONE, ONE, '0, ONE, '0, '0));
        send_beat(make_req(OP_DIV, ONE, -ONE, ONE, WORD_MAX, '0, '0, '0, '0));
        send_beat(make_req(OP_DIV, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, '0, '0, '0, 1));
        send_beat(make_req(OP_CONJ, WORD_MIN, WORD_MIN, WORD_MAX, '0, '0, '0, '0, '0));
        send_beat(make_req(OP_INV, '0, '0, '0, '0, ONE, ONE, ONE, ONE));
        send_beat(make_req(OP_INV, '0, '0, '0, 1, '0, '0, '0, '0));
        send_beat(make_req(OP_INV, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, '0, '0, '0, '0));
        send_beat(make_req(OP_NORMZ, '0, '0, '0, '0, '0, '0, '0, '0));
        send_beat(make_req(OP_NORMZ, 1, '0, '0, '0, '0, '0, '0, '0));
        send_beat(make_req(OP_NORMZ, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, '0, '0, '0, '0));
        send_beat(make_req(OP_NORM, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, '0, '0, '0, '0));
        send_beat(make_req(OP_NORM, ONE, ONE, ONE, ONE, '0, '0, '0, '0));
        send_beat(make_req(OP_DOT, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                           WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
        send_beat(make_req(OP_DOT, -ONE, ONE, ONE, ONE, ONE, ONE, -ONE, ONE));
        send_beat(make_req(OP_DIST, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                           WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
        send_beat(make_req(OP_DIST, ONE, '0, '0, '0, '0, '0, '0, '0));
        send_beat(make_req(OP_CHEB, WORD_MAX, '0, '0, '0, WORD_MIN, '0, '0, '0));
        send_beat(make_req(OP_CHEB, ONE, -ONE, '0, '0, '0, '0, ONE, '0));
        send_beat(make_req(4'd11, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
        send_beat(make_req(4'd15, WORD_MAX, WORD_MIN, ONE, -ONE, 1, 2, 3, 4));

        // random beats; mostly valid opcodes, a few unknown ones
        for (int i = 0; i < RAND_BEATS; i++) begin
            if (i == RAND_BEATS - CALM_BEATS) calm <= 1'b1;
            if (i == RAND_BEATS / 2) begin
                // hold off until every result has drained
                s_valid <= 1'b0;
                @(posedge aclk);
                while (pending != 0) @(posedge aclk);
            end
            maybe_gap();
            r = make_req($urandom_range(0, 32) == 0 ? 4'($urandom_range(11, 15))
                                                      : 4'($urandom_range(0, 10)),
                         rand_word(), rand_word(), rand_word(), rand_word(),
                         rand_word(), rand_word(), rand_word(), rand_word());
            if ($urandom_range(0, 15) == 0) begin
                r.op1_w = '0; r.op1_x = '0; r.op1_y = '0; r.op1_z = '0;
            end
            if ($urandom_range(0, 15) == 0) begin
                r.op2_w = '0; r.op2_x = '0; r.op2_y = '0; r.op2_z = '0;
            end
            send_beat(r);
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
